// ----- rtl/core/npcs_pkg.sv -----
// ----------------------------------------------------------------------------
// npcs_pkg
// Shared types and constants for the nearest palette colour search unit.
// ----------------------------------------------------------------------------
package npcs_pkg;

   // palette depth; only entries below the 8-bit index span can be reached
   localparam int PALETTE_ENTRIES = 256;
   localparam int INDEX_SPAN      = 256;
   localparam int SCAN            = (PALETTE_ENTRIES < INDEX_SPAN) ? PALETTE_ENTRIES
                                                                  : INDEX_SPAN;

   localparam int PAL_AW  = $clog2(PALETTE_ENTRIES);
   localparam int SCAN_AW = $clog2(SCAN);

   localparam int CMD_W   = 1;
   localparam int IDX_W   = 8;
   localparam int RGB_W   = 24;
   localparam int CHAN_W  = 8;
   localparam int SQ_W    = 2 * CHAN_W;
   localparam int DIST_W  = 18;

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_PAD_W   = RSP_TDATA_W - IDX_W - DIST_W;

   // largest real distance is 3*255^2, well under an all-ones 18-bit word
   localparam logic [DIST_W-1:0] DIST_INIT  = '1;
   localparam logic [DIST_W-1:0] DIST_MAX   = 18'd195075;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } npcs_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } npcs_state_type;

endpackage

// ----- rtl/core/nearest_palette_color_search_unit.sv -----
// ----------------------------------------------------------------------------
// nearest_palette_color_search_unit
// Palette store with a sequential nearest-colour scan (squared RGB distance).
// ----------------------------------------------------------------------------
//  channel | direction | word contents (low bit first)            | results
//  req_    | in        | tuser: command; tdata: index, rgb        | load: none
//  rsp_    | out       | tdata: match_index, match_distance, pad  | one per query
//
//  A load is taken in idle and writes the palette RAM at acceptance.
//  A query reads the RAM once per entry, set by the single read port; each read
//  then passes the read register, the square stage and the compare stage.
//  The result sits in an output register; loads are taken while it waits, a
//  further query scans but holds its result until that register is free.
//  Reset is synchronous and clears control only; palette contents are kept.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [npcs_pkg::REQ_TDATA_W-1:0]   req_tdata,  // [7:0] entry_index, [31:8] color_rgb
   input  logic [npcs_pkg::CMD_W-1:0]         req_tuser,  // [0] command
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [npcs_pkg::RSP_TDATA_W-1:0]   rsp_tdata   // [7:0] match_index,
                                                          // [25:8] match_distance, [31:26] zero
);

   npcs_pkg::npcs_state_type state_ff, state_in;

   logic [npcs_pkg::SCAN_AW-1:0] cnt_ff, cnt_in;
   logic                         rd_en;
   logic                         wr_en;
   logic                         rsp_load;
   logic                         req_acc;

   logic [npcs_pkg::IDX_W-1:0]   in_idx;
   logic [npcs_pkg::RGB_W-1:0]   in_rgb;

   logic [npcs_pkg::RGB_W-1:0]   mem [npcs_pkg::PALETTE_ENTRIES];
   logic [npcs_pkg::RGB_W-1:0]   rd_data_ff;
   logic [npcs_pkg::RGB_W-1:0]   qcolor_ff;

   logic                         s1_vld_ff;
   logic [npcs_pkg::IDX_W-1:0]   s1_idx_ff;
   logic                         s2_vld_ff;
   logic [npcs_pkg::IDX_W-1:0]   s2_idx_ff;
   logic [npcs_pkg::SQ_W-1:0]    sq_r_ff, sq_g_ff, sq_b_ff;
   logic [npcs_pkg::SQ_W-1:0]    sq_r_in, sq_g_in, sq_b_in;
   logic [npcs_pkg::DIST_W-1:0]  cur_dist;

   logic [npcs_pkg::IDX_W-1:0]   best_idx_ff;
   logic [npcs_pkg::DIST_W-1:0]  best_dist_ff;

   logic                         rsp_tvalid_ff, rsp_tvalid_in;
   logic [npcs_pkg::IDX_W-1:0]   rsp_idx_ff;
   logic [npcs_pkg::DIST_W-1:0]  rsp_dist_ff;

   assign in_idx  = req_tdata[npcs_pkg::IDX_W-1:0];
   assign in_rgb  = req_tdata[npcs_pkg::IDX_W +: npcs_pkg::RGB_W];
   assign req_acc = req_tvalid & req_tready;
   assign wr_en   = req_acc && (req_tuser == npcs_pkg::CMD_LOAD) &&
                    (32'(in_idx) < npcs_pkg::PALETTE_ENTRIES);

   // control
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      req_tready = 1'b0;
      rd_en      = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         npcs_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && (req_tuser == npcs_pkg::CMD_QUERY)) begin
               state_in = npcs_pkg::ST_SCAN;
               cnt_in   = '0;
            end
         end
         npcs_pkg::ST_SCAN: begin
            rd_en = 1'b1;
            if (cnt_ff == npcs_pkg::SCAN_AW'(npcs_pkg::SCAN - 1)) begin
               state_in = npcs_pkg::ST_FINISH;
            end else begin
               cnt_in = cnt_ff + npcs_pkg::SCAN_AW'(1);
            end
         end
         npcs_pkg::ST_FINISH: begin
            // wait for the pipe to drain and the output register to free up
            if (!s1_vld_ff && !s2_vld_ff && (!rsp_tvalid_ff || rsp_tready)) begin
               rsp_load = 1'b1;
               state_in = npcs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = npcs_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid_in = rsp_load | (rsp_tvalid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= npcs_pkg::ST_IDLE;
         s1_vld_ff     <= 1'b0;
         s2_vld_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         s1_vld_ff     <= rd_en;
         s2_vld_ff     <= s1_vld_ff;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
   end

   // palette RAM, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[npcs_pkg::PAL_AW'(in_idx)] <= in_rgb;
      end
      if (rd_en) begin
         rd_data_ff <= mem[npcs_pkg::PAL_AW'(cnt_ff)];
      end
   end

   // squared channel differences
   always_comb begin
      logic [npcs_pkg::CHAN_W-1:0] p, q, d;
      sq_r_in = '0;
      sq_g_in = '0;
      sq_b_in = '0;
      for (int c = 0; c < 3; c++) begin
         p = rd_data_ff[c*npcs_pkg::CHAN_W +: npcs_pkg::CHAN_W];
         q = qcolor_ff[c*npcs_pkg::CHAN_W +: npcs_pkg::CHAN_W];
         d = (p > q) ? (p - q) : (q - p);
         case (c)
            0:       sq_r_in = npcs_pkg::SQ_W'(d) * npcs_pkg::SQ_W'(d);
            1:       sq_g_in = npcs_pkg::SQ_W'(d) * npcs_pkg::SQ_W'(d);
            default: sq_b_in = npcs_pkg::SQ_W'(d) * npcs_pkg::SQ_W'(d);
         endcase
      end
   end

   assign cur_dist = npcs_pkg::DIST_W'(sq_r_ff) + npcs_pkg::DIST_W'(sq_g_ff) +
                     npcs_pkg::DIST_W'(sq_b_ff);

   always_ff @(posedge clock) begin
      if (req_acc && (req_tuser == npcs_pkg::CMD_QUERY)) begin
         qcolor_ff    <= in_rgb;
         best_dist_ff <= npcs_pkg::DIST_INIT;
         best_idx_ff  <= '0;
      end else if (s2_vld_ff && (cur_dist < best_dist_ff)) begin
         // strict compare keeps the lowest index on a tie
         best_dist_ff <= cur_dist;
         best_idx_ff  <= s2_idx_ff;
      end
      s1_idx_ff <= npcs_pkg::IDX_W'(cnt_ff);
      s2_idx_ff <= s1_idx_ff;
      sq_r_ff   <= sq_r_in;
      sq_g_ff   <= sq_g_in;
      sq_b_ff   <= sq_b_in;
      if (rsp_load) begin
         rsp_idx_ff  <= best_idx_ff;
         rsp_dist_ff <= best_dist_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{npcs_pkg::RSP_PAD_W{1'b0}}, rsp_dist_ff, rsp_idx_ff};

endmodule

// ----- rtl/core/npcs_port_checker.sv -----
// ----------------------------------------------------------------------------
// npcs_port_checker
// Port-level checks for the nearest palette colour search unit.
// ----------------------------------------------------------------------------
module npcs_port_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [npcs_pkg::CMD_W-1:0]         req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [npcs_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   // a stalled result word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[npcs_pkg::RSP_TDATA_W-1:npcs_pkg::IDX_W+npcs_pkg::DIST_W] == '0)
      else $error("result padding not zero");

   a_rsp_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         rsp_tdata[npcs_pkg::IDX_W +: npcs_pkg::DIST_W] <= npcs_pkg::DIST_MAX)
      else $error("match distance out of range");

   // a query occupies the scanner, so nothing is taken the next cycle
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == npcs_pkg::CMD_QUERY) |=> !req_tready)
      else $error("input taken during a scan");

endmodule

bind nearest_palette_color_search_unit npcs_port_checker u_npcs_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
